/* rtl/iss_pkg.sv */
`timescale 1ns / 1ps
// Package for the indexed sequence store: field widths, function codes,
// transfer payload structs, cell control struct and the control state type.
// Depends on nothing.
package iss_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int FUNC_W  = 3;
    localparam int POS_W   = 7;
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 7;

    localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd5;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [POS_W-1:0]  position;
        logic [WORD_W-1:0] word_in;
    } in_t;

    typedef struct packed {
        logic               ok;
        logic [WORD_W-1:0]  word_out;
        logic [COUNT_W-1:0] count;
    } out_t;

    typedef struct packed {
        logic write_en;
        logic append_en;
        logic insert_en;
        logic remove_en;
        logic capture;
        logic tap_shift;
    } cell_ctrl_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } state_t;

endpackage

/* rtl/indexed_sequence_store_top.sv */
`timescale 1ns / 1ps
// Top level of the indexed sequence store: request decode, control FSM,
// element count, chain of iss_cell instances and two-entry result buffer.
// Depends on iss_pkg and iss_cell.
//
//  channel   direction  handshake           payload
//  s_        in         s_valid / s_ready   s_data (iss_pkg::in_t)
//  m_        out        m_valid / m_ready   m_data (iss_pkg::out_t)
//
// Write, append, insert, remove, clear and refused requests are answered without a scan.
// A read that succeeds enters the scan state: the read tap chain moves
// the captured words one cell toward cell 0 per cycle.
// Reset clears the count and the control state; cell contents are undefined.
// A stalled m_ready holds up to two results; s_ready drops while both wait.
module indexed_sequence_store_top #(
    parameter int DEPTH      = iss_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = iss_pkg::DATA_WIDTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  iss_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output iss_pkg::out_t m_data
);

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMP_W = (CW > iss_pkg::POS_W) ? CW : iss_pkg::POS_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

    iss_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [iss_pkg::POS_W-1:0] down_reg, down_next;

    logic          m_valid_reg, m_valid_next;
    iss_pkg::out_t m_data_reg, m_data_next;
    logic          skid_valid_reg, skid_valid_next;
    iss_pkg::out_t skid_data_reg, skid_data_next;

    iss_pkg::cell_ctrl_t ctrl;
    logic accept, pop, push, scan_done;
    logic [CMP_W-1:0] pos_e, cnt_e;
    logic read_ok, write_ok, append_ok, insert_ok, remove_ok, is_read, op_ok;
    logic [DATA_WIDTH-1:0] word_fit;
    iss_pkg::out_t res;

    logic [DATA_WIDTH-1:0] data_w [DEPTH];
    logic [DATA_WIDTH-1:0] tap_w  [DEPTH];

    assign pos_e    = CMP_W'(s_data.position);
    assign cnt_e    = CMP_W'(cnt_reg);
    assign word_fit = DATA_WIDTH'(s_data.word_in);

    assign is_read   = s_data.func == iss_pkg::FUNC_READ;
    assign read_ok   = is_read && pos_e < cnt_e;
    assign write_ok  = s_data.func == iss_pkg::FUNC_WRITE && pos_e < cnt_e;
    assign append_ok = s_data.func == iss_pkg::FUNC_APPEND && cnt_e < DEPTH_C;
    assign insert_ok = s_data.func == iss_pkg::FUNC_INSERT && pos_e <= cnt_e
                       && cnt_e < DEPTH_C;
    assign remove_ok = s_data.func == iss_pkg::FUNC_REMOVE && pos_e < cnt_e;
    assign op_ok     = write_ok || append_ok || insert_ok || remove_ok
                       || s_data.func == iss_pkg::FUNC_CLEAR;

    assign accept    = s_valid && s_ready;
    assign pop       = m_valid_reg && m_ready;
    assign scan_done = state_reg == iss_pkg::ST_SCAN && down_reg == '0;
    assign push      = (accept && !read_ok) || scan_done;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            iss_pkg::ST_IDLE: begin
                if (accept && read_ok) begin
                    state_next = iss_pkg::ST_SCAN;
                end
            end
            iss_pkg::ST_SCAN: begin
                if (down_reg == '0) begin
                    state_next = iss_pkg::ST_IDLE;
                end
            end
            default: state_next = iss_pkg::ST_IDLE;
        endcase
    end

    // outputs and cell control
    always_comb begin
        s_ready = 1'b0;
        ctrl    = '0;
        case (state_reg)
            iss_pkg::ST_IDLE: begin
                s_ready        = !skid_valid_reg;
                ctrl.write_en  = accept && write_ok;
                ctrl.append_en = accept && append_ok;
                ctrl.insert_en = accept && insert_ok;
                ctrl.remove_en = accept && remove_ok;
                ctrl.capture   = accept && read_ok;
            end
            iss_pkg::ST_SCAN: begin
                ctrl.tap_shift = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (accept) begin
            if (append_ok || insert_ok) begin
                cnt_next = cnt_reg + CW'(1);
            end else if (remove_ok) begin
                cnt_next = cnt_reg - CW'(1);
            end else if (s_data.func == iss_pkg::FUNC_CLEAR) begin
                cnt_next = '0;
            end
        end
    end

    always_comb begin
        down_next = down_reg;
        if (accept && read_ok) begin
            down_next = s_data.position;
        end else if (state_reg == iss_pkg::ST_SCAN && down_reg != '0) begin
            down_next = down_reg - iss_pkg::POS_W'(1);
        end
    end

    always_comb begin
        res.count = iss_pkg::COUNT_W'(cnt_next);
        if (scan_done) begin
            res.ok       = 1'b1;
            res.word_out = iss_pkg::WORD_W'(tap_w[0]);
        end else begin
            res.ok       = op_ok;
            res.word_out = '0;
        end
    end

    // two-entry result buffer
    always_comb begin
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                m_data_next     = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = res;
            end else begin
                m_valid_next = push;
                m_data_next  = res;
            end
        end else if (push) begin
            if (!m_valid_reg) begin
                m_valid_next = 1'b1;
                m_data_next  = res;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= iss_pkg::ST_IDLE;
            cnt_reg        <= '0;
            down_reg       <= '0;
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            down_reg       <= down_next;
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg    <= m_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_d, right_d, right_t;
        if (i == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid
            assign left_d = data_w[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign right_d = '0;
            assign right_t = '0;
        end else begin : g_inner
            assign right_d = data_w[i+1];
            assign right_t = tap_w[i+1];
        end
        iss_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CMP_W      (CMP_W),
            .INDEX      (i)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .pos        (pos_e),
            .cnt        (cnt_e),
            .word_in    (word_fit),
            .left_data  (left_d),
            .right_data (right_d),
            .right_tap  (right_t),
            .data       (data_w[i]),
            .tap        (tap_w[i])
        );
    end

    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("result buffer holds second entry without first");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && skid_valid_reg && !pop))
        else $error("result pushed into full buffer");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(cnt_reg) <= DEPTH_C)
        else $error("element count beyond depth");

    a_read_scans: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && read_ok) |=> (state_reg == iss_pkg::ST_SCAN && !s_ready))
        else $error("read transfer did not start a scan");

    a_count_held_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == iss_pkg::ST_SCAN) |=> $stable(cnt_reg))
        else $error("count changed during read scan");

endmodule

/* rtl/iss_cell.sv */
`timescale 1ns / 1ps
// One storage cell of the sequence chain: holds one word and one read tap,
// exchanges words with both neighbors. Depends on iss_pkg.
module iss_cell #(
    parameter int DATA_WIDTH = iss_pkg::DATA_WIDTH_DEF,
    parameter int CMP_W      = iss_pkg::POS_W,
    parameter int INDEX      = 0
) (
    input  logic                    aclk,
    input  iss_pkg::cell_ctrl_t     ctrl,
    input  logic [CMP_W-1:0]        pos,
    input  logic [CMP_W-1:0]        cnt,
    input  logic [DATA_WIDTH-1:0]   word_in,
    input  logic [DATA_WIDTH-1:0]   left_data,
    input  logic [DATA_WIDTH-1:0]   right_data,
    input  logic [DATA_WIDTH-1:0]   right_tap,
    output logic [DATA_WIDTH-1:0]   data,
    output logic [DATA_WIDTH-1:0]   tap
);

    localparam logic [CMP_W-1:0] IDX   = CMP_W'(INDEX);
    localparam logic [CMP_W-1:0] IDX_1 = CMP_W'(INDEX + 1);

    logic [DATA_WIDTH-1:0] data_reg, data_next;
    logic [DATA_WIDTH-1:0] tap_reg, tap_next;

    always_comb begin
        data_next = data_reg;
        if (ctrl.write_en && IDX == pos) begin
            data_next = word_in;
        end else if (ctrl.append_en && IDX == cnt) begin
            data_next = word_in;
        end else if (ctrl.insert_en) begin
            if (IDX == pos) begin
                data_next = word_in;
            end else if (IDX > pos && IDX <= cnt) begin
                data_next = left_data;
            end
        end else if (ctrl.remove_en && IDX >= pos && IDX_1 < cnt) begin
            data_next = right_data;
        end
    end

    always_comb begin
        tap_next = tap_reg;
        if (ctrl.capture) begin
            tap_next = data_reg;
        end else if (ctrl.tap_shift) begin
            tap_next = right_tap;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        tap_reg  <= tap_next;
    end

    assign data = data_reg;
    assign tap  = tap_reg;

endmodule

/* sim/tb_indexed_sequence_store_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for indexed_sequence_store_top: directed and random requests,
// a mirror of the stored sequence that predicts each result, and random flow control.
// Depends on iss_pkg and the RTL of the indexed sequence store.

class store_mirror;
    logic [iss_pkg::WORD_W-1:0] cells [iss_pkg::DEPTH_DEF];
    int unsigned                fill;
    iss_pkg::out_t              awaited [$];
    int unsigned                mismatches;

    function new();
        foreach (cells[i]) cells[i] = '0;
        fill       = 0;
        mismatches = 0;
    endfunction

    function int unsigned occupancy();
        return fill;
    endfunction

    function int unsigned outstanding();
        return awaited.size();
    endfunction

    function void apply_request(iss_pkg::in_t req);
        iss_pkg::out_t res;
        int unsigned   pos;
        res = '0;
        pos = req.position;
        case (req.func)
            iss_pkg::FUNC_READ: begin
                if (pos < fill) begin
                    res.ok       = 1'b1;
                    res.word_out = cells[pos];
                end
            end
            iss_pkg::FUNC_WRITE: begin
                if (pos < fill) begin
                    cells[pos] = req.word_in;
                    res.ok     = 1'b1;
                end
            end
            iss_pkg::FUNC_APPEND: begin
                if (fill < iss_pkg::DEPTH_DEF) begin
                    cells[fill] = req.word_in;
                    fill++;
                    res.ok = 1'b1;
                end
            end
            iss_pkg::FUNC_INSERT: begin
                if (pos <= fill && fill < iss_pkg::DEPTH_DEF) begin
                    for (int unsigned i = fill; i > pos; i--) cells[i] = cells[i-1];
                    cells[pos] = req.word_in;
                    fill++;
                    res.ok = 1'b1;
                end
            end
            iss_pkg::FUNC_REMOVE: begin
                if (pos < fill) begin
                    for (int unsigned i = pos; i + 1 < fill; i++) cells[i] = cells[i+1];
                    fill--;
                    res.ok = 1'b1;
                end
            end
            iss_pkg::FUNC_CLEAR: begin
                fill   = 0;
                res.ok = 1'b1;
            end
            default: ;
        endcase
        res.count = iss_pkg::COUNT_W'(fill);
        awaited.push_back(res);
    endfunction

    function void match_result(iss_pkg::out_t got);
        iss_pkg::out_t exp_res;
        if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result ok=%0b word=%08h count=%0d",
                         got.ok, got.word_out, got.count);
            return;
        end
        exp_res = awaited.pop_front();
        if (got.ok !== exp_res.ok || got.word_out !== exp_res.word_out ||
            got.count !== exp_res.count) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch exp ok=%0b word=%08h cnt=%0d got ok=%0b word=%08h cnt=%0d",
                         exp_res.ok, exp_res.word_out, exp_res.count,
                         got.ok, got.word_out, got.count);
        end
    endfunction
endclass

module tb_indexed_sequence_store_top;

    localparam int unsigned RANDOM_ITEMS    = 1125;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned QUIET_LIMIT     = 3000;
    localparam int unsigned DRAIN_CYCLES    = iss_pkg::DEPTH_DEF + 16;

    localparam logic [iss_pkg::FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
    localparam logic [iss_pkg::FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

    typedef enum logic [1:0] {
        MIX_GROW,
        MIX_SHRINK,
        MIX_BALANCED
    } traffic_mix_t;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_RANDOM,
        READY_EVERY_THIRD,
        READY_BURSTY
    } ready_style_t;

    logic           aclk;
    logic           aresetn;
    logic           s_valid;
    logic           s_ready;
    iss_pkg::in_t   s_data;
    logic           m_valid;
    logic           m_ready;
    iss_pkg::out_t  m_data;

    bit          hold_off_req;
    store_mirror mirror;

    indexed_sequence_store_top i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic iss_pkg::in_t make_req(logic [iss_pkg::FUNC_W-1:0] f,
                                              int unsigned pos,
                                              logic [iss_pkg::WORD_W-1:0] w);
        iss_pkg::in_t req;
        req.func     = f;
        req.position = iss_pkg::POS_W'(pos);
        req.word_in  = w;
        return req;
    endfunction

    function automatic iss_pkg::in_t next_request(traffic_mix_t mix, int unsigned fill);
        iss_pkg::in_t               req;
        int unsigned                roll;
        int unsigned                top;
        logic [iss_pkg::FUNC_W-1:0] f;
        bit                         noise;
        roll  = $urandom_range(99);
        noise = 1'b0;
        f     = iss_pkg::FUNC_READ;
        case (mix)
            MIX_GROW: begin
                if (roll < 35)      f = iss_pkg::FUNC_APPEND;
                else if (roll < 70) f = iss_pkg::FUNC_INSERT;
                else if (roll < 80) f = iss_pkg::FUNC_READ;
                else if (roll < 88) f = iss_pkg::FUNC_WRITE;
                else if (roll < 94) f = iss_pkg::FUNC_REMOVE;
                else                noise = 1'b1;
            end
            MIX_SHRINK: begin
                if (roll < 55)      f = iss_pkg::FUNC_REMOVE;
                else if (roll < 66) f = iss_pkg::FUNC_READ;
                else if (roll < 74) f = iss_pkg::FUNC_WRITE;
                else if (roll < 81) f = iss_pkg::FUNC_APPEND;
                else if (roll < 88) f = iss_pkg::FUNC_INSERT;
                else if (roll < 90) f = iss_pkg::FUNC_CLEAR;
                else                noise = 1'b1;
            end
            default: begin
                if (roll < 25)      f = iss_pkg::FUNC_READ;
                else if (roll < 45) f = iss_pkg::FUNC_WRITE;
                else if (roll < 60) f = iss_pkg::FUNC_APPEND;
                else if (roll < 75) f = iss_pkg::FUNC_INSERT;
                else if (roll < 90) f = iss_pkg::FUNC_REMOVE;
                else if (roll < 93) f = iss_pkg::FUNC_CLEAR;
                else                noise = 1'b1;
            end
        endcase
        roll = $urandom_range(9);
        if (roll == 0)      req.word_in = '0;
        else if (roll == 1) req.word_in = '1;
        else                req.word_in = $urandom();
        if (noise) begin
            req.func     = iss_pkg::FUNC_W'($urandom_range(7));
            req.position = iss_pkg::POS_W'($urandom_range(127));
            return req;
        end
        req.func = f;
        if ($urandom_range(99) < 12 || f == iss_pkg::FUNC_APPEND ||
            f == iss_pkg::FUNC_CLEAR) begin
            req.position = iss_pkg::POS_W'($urandom_range(127));
        end else if (f == iss_pkg::FUNC_INSERT) begin
            req.position = iss_pkg::POS_W'($urandom_range(fill));
        end else if (fill == 0) begin
            req.position = iss_pkg::POS_W'($urandom_range(127));
        end else begin
            top = (fill - 1 < 7 || $urandom_range(1) == 0) ? fill - 1 : 7;
            req.position = iss_pkg::POS_W'($urandom_range(top));
        end
        return req;
    endfunction

    task automatic push_request(input iss_pkg::in_t req);
        @(negedge aclk);
        s_data  <= req;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        mirror.apply_request(req);
    endtask

    task automatic pause(input int unsigned cycles);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (cycles - 1) @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) mirror.match_result(m_data);
    end

    // receiver flow control
    initial begin
        int unsigned  tick;
        int unsigned  stall_left;
        ready_style_t style;
        m_ready    = 1'b0;
        tick       = 0;
        stall_left = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end
            tick++;
            style = ready_style_t'((tick / 300) % 4);
            case (style)
                READY_ALWAYS:      m_ready <= 1'b1;
                READY_RANDOM:      m_ready <= ($urandom_range(99) < 60);
                READY_EVERY_THIRD: m_ready <= (tick % 3 == 0);
                default: begin
                    if (stall_left != 0) begin
                        stall_left--;
                        m_ready <= 1'b0;
                    end else begin
                        m_ready <= 1'b1;
                        if ($urandom_range(9) == 0) stall_left = $urandom_range(1, 12);
                    end
                end
            endcase
        end
    end

    // watchdog on transfers
    initial begin
        int unsigned quiet;
        quiet = 0;
        @(posedge aresetn);
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        iss_pkg::in_t directed [$];
        int unsigned  burst_left;
        traffic_mix_t mix;
        mirror       = new();
        hold_off_req = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        burst_left   = 0;
        mix          = MIX_GROW;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        directed.push_back(make_req(iss_pkg::FUNC_READ,   0,   32'h0000_0000));
        directed.push_back(make_req(iss_pkg::FUNC_REMOVE, 0,   32'h0000_0000));
        directed.push_back(make_req(iss_pkg::FUNC_WRITE,  0,   32'hFFFF_FFFF));
        directed.push_back(make_req(iss_pkg::FUNC_INSERT, 1,   32'hFFFF_FFFF));
        directed.push_back(make_req(iss_pkg::FUNC_INSERT, 0,   32'hFFFF_FFFF));
        directed.push_back(make_req(iss_pkg::FUNC_APPEND, 127, 32'h0000_0000));
        directed.push_back(make_req(iss_pkg::FUNC_INSERT, 2,   32'hA5A5_A5A5));
        directed.push_back(make_req(iss_pkg::FUNC_INSERT, 1,   32'h1234_5678));
        directed.push_back(make_req(iss_pkg::FUNC_READ,   0,   32'h0000_0000));
        directed.push_back(make_req(iss_pkg::FUNC_READ,   3,   32'hFFFF_FFFF));
        directed.push_back(make_req(iss_pkg::FUNC_READ,   4,   32'h0000_0000));
        directed.push_back(make_req(iss_pkg::FUNC_WRITE,  3,   32'h0000_0000));
        directed.push_back(make_req(iss_pkg::FUNC_READ,   3,   32'h0000_0000));
        directed.push_back(make_req(iss_pkg::FUNC_REMOVE, 1,   32'h0000_0000));
        directed.push_back(make_req(iss_pkg::FUNC_READ,   1,   32'h0000_0000));
        directed.push_back(make_req(iss_pkg::FUNC_REMOVE, 2,   32'h0000_0000));
        directed.push_back(make_req(iss_pkg::FUNC_READ,   127, 32'h0000_0000));
        directed.push_back(make_req(iss_pkg::FUNC_INSERT, 64,  32'hFFFF_FFFF));
        directed.push_back(make_req(iss_pkg::FUNC_WRITE,  127, 32'hFFFF_FFFF));
        directed.push_back(make_req(FUNC_SPARE_LO,        0,   32'hFFFF_FFFF));
        directed.push_back(make_req(FUNC_SPARE_HI,        127, 32'h0000_0000));
        directed.push_back(make_req(iss_pkg::FUNC_CLEAR,  0,   32'h0000_0000));
        directed.push_back(make_req(iss_pkg::FUNC_READ,   0,   32'h0000_0000));
        directed.push_back(make_req(iss_pkg::FUNC_APPEND, 0,   32'h5A5A_5A5A));
        directed.push_back(make_req(iss_pkg::FUNC_READ,   0,   32'h0000_0000));

        foreach (directed[i]) begin
            if ($urandom_range(3) == 0) pause($urandom_range(1, 3));
            push_request(directed[i]);
        end

        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 300 || n == 800) hold_off_req = 1'b1;
            if (burst_left == 0) begin
                if ($urandom_range(3) != 0) pause($urandom_range(1, 20));
                burst_left = ($urandom_range(7) == 0) ? $urandom_range(60, 150)
                                                      : $urandom_range(1, 16);
            end
            burst_left--;
            case (mix)
                MIX_GROW: begin
                    if (mirror.occupancy() == iss_pkg::DEPTH_DEF && $urandom_range(4) == 0)
                        mix = MIX_SHRINK;
                end
                MIX_SHRINK: begin
                    if (mirror.occupancy() == 0 && $urandom_range(2) == 0)
                        mix = ($urandom_range(1) == 0) ? MIX_GROW : MIX_BALANCED;
                end
                default: begin
                    if ($urandom_range(79) == 0) mix = MIX_GROW;
                end
            endcase
            push_request(next_request(mix, mirror.occupancy()));
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (mirror.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mirror.mismatches == 0 && mirror.outstanding() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
